FILE: sv/cpu_alu_pkg.sv
// package for the cpu alu: operation codes, flag bit positions and field widths
// no dependencies; compiled before the interfaces and all modules
package cpu_alu_pkg;

    localparam int OP_W    = 5;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int FLAGS_W = 4;
    localparam int BIDX_W  = 3;

    // flag bit positions in flags_in / flags_out
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_CP    = 5'd4,
        OP_AND   = 5'd5,
        OP_OR    = 5'd6,
        OP_XOR   = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_CPL   = 5'd10,
        OP_RLC   = 5'd11,
        OP_RRC   = 5'd12,
        OP_RL    = 5'd13,
        OP_RR    = 5'd14,
        OP_SLA   = 5'd15,
        OP_SRA   = 5'd16,
        OP_SRL   = 5'd17,
        OP_SWAP  = 5'd18,
        OP_BIT   = 5'd19,
        OP_RES   = 5'd20,
        OP_SET   = 5'd21,
        OP_RLCA  = 5'd22,
        OP_RRCA  = 5'd23,
        OP_RLA   = 5'd24,
        OP_RRA   = 5'd25,
        OP_ADD16 = 5'd26,
        OP_ADDSP = 5'd27,
        OP_INC16 = 5'd28,
        OP_DEC16 = 5'd29
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [WORD_W-1:0]  operand_a;
        logic [WORD_W-1:0]  operand_b;
        logic [FLAGS_W-1:0] flags_in;
        logic [BIDX_W-1:0]  bit_index;
    } alu_req_t;

    typedef struct packed {
        logic [WORD_W-1:0]  result;
        logic [FLAGS_W-1:0] flags_out;
        logic               write_result;
    } alu_rsp_t;

endpackage

FILE: sv/cpu_alu_if.sv
// valid/ready channel interfaces for the cpu alu: operation request and result
// depends on cpu_alu_pkg for field widths
interface cpu_alu_req_if
    import cpu_alu_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [WORD_W-1:0]   operand_a;
    logic [WORD_W-1:0]   operand_b;
    logic [FLAGS_W-1:0]  flags_in;
    logic [BIDX_W-1:0]   bit_index;

    modport source (output valid, operation, operand_a, operand_b, flags_in, bit_index,
                    input ready);
    modport sink   (input valid, operation, operand_a, operand_b, flags_in, bit_index,
                    output ready);
endinterface

interface cpu_alu_rsp_if
    import cpu_alu_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   result;
    logic [FLAGS_W-1:0]  flags_out;
    logic                write_result;

    modport source (output valid, result, flags_out, write_result, input ready);
    modport sink   (input valid, result, flags_out, write_result, output ready);
endinterface

FILE: sv/cpu_alu_core.sv
// combinational datapath of the cpu alu: 8/16-bit arithmetic, logic, shifts, bit ops
// depends on cpu_alu_pkg
module cpu_alu_core
    import cpu_alu_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [BYTE_W-1:0]  a;
    logic [BYTE_W-1:0]  b;
    logic               cin;
    logic               carry_t;
    logic [BYTE_W:0]    sum9;
    logic [4:0]         half_sum;
    logic [BYTE_W:0]    diff9;
    logic [4:0]         half_diff;
    logic [WORD_W:0]    sum17;
    logic [12:0]        sum13;
    logic [WORD_W-1:0]  offset16;
    logic [BYTE_W:0]    sp_low9;
    logic [4:0]         sp_half;
    logic [BYTE_W-1:0]  bit_mask;
    logic [WORD_W-1:0]  r;
    logic [FLAGS_W-1:0] f;
    logic               wr;

    assign a   = req.operand_a[BYTE_W-1:0];
    assign b   = req.operand_b[BYTE_W-1:0];
    assign cin = req.flags_in[FLAG_C];

    // carry/borrow in only for adc and sbc
    assign carry_t = ((op_t'(req.operation) == OP_ADC) || (op_t'(req.operation) == OP_SBC))
                     ? cin : 1'b0;

    assign sum9      = {1'b0, a} + {1'b0, b} + {{BYTE_W{1'b0}}, carry_t};
    assign half_sum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_t};
    assign diff9     = {1'b0, a} - {1'b0, b} - {{BYTE_W{1'b0}}, carry_t};
    assign half_diff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_t};

    assign sum17    = {1'b0, req.operand_a} + {1'b0, req.operand_b};
    assign sum13    = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
    assign offset16 = {{BYTE_W{b[BYTE_W-1]}}, b};
    assign sp_low9  = {1'b0, req.operand_a[BYTE_W-1:0]} + {1'b0, b};
    assign sp_half  = {1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]};

    assign bit_mask = BYTE_W'(1) << req.bit_index;

    always_comb
    begin
        r  = '0;
        f  = req.flags_in;
        wr = 1'b1;
        case (op_t'(req.operation))
            OP_ADD, OP_ADC:
            begin
                r = {8'd0, sum9[BYTE_W-1:0]};
                f = {sum9[BYTE_W-1:0] == '0, 1'b0, half_sum[4], sum9[BYTE_W]};
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                r  = {8'd0, diff9[BYTE_W-1:0]};
                f  = {diff9[BYTE_W-1:0] == '0, 1'b1, half_diff[4], diff9[BYTE_W]};
                wr = (op_t'(req.operation) != OP_CP);
            end
            OP_AND:
            begin
                r = {8'd0, a & b};
                f = {(a & b) == '0, 1'b0, 1'b1, 1'b0};
            end
            OP_OR:
            begin
                r = {8'd0, a | b};
                f = {(a | b) == '0, 3'b000};
            end
            OP_XOR:
            begin
                r = {8'd0, a ^ b};
                f = {(a ^ b) == '0, 3'b000};
            end
            OP_INC:
            begin
                r = {8'd0, a + 8'd1};
                f = {a == 8'hFF, 1'b0, a[3:0] == 4'hF, cin};
            end
            OP_DEC:
            begin
                r = {8'd0, a - 8'd1};
                f = {a == 8'h01, 1'b1, a[3:0] == 4'h0, cin};
            end
            OP_CPL:
            begin
                r = {8'd0, ~a};
                f = {req.flags_in[FLAG_Z], 1'b1, 1'b1, cin};
            end
            OP_RLC, OP_RLCA:
            begin
                r = {8'd0, a[6:0], a[7]};
                f = {3'b000, a[7]};
            end
            OP_RRC, OP_RRCA:
            begin
                r = {8'd0, a[0], a[7:1]};
                f = {3'b000, a[0]};
            end
            OP_RL, OP_RLA:
            begin
                r = {8'd0, a[6:0], cin};
                f = {3'b000, a[7]};
            end
            OP_RR, OP_RRA:
            begin
                r = {8'd0, cin, a[7:1]};
                f = {3'b000, a[0]};
            end
            OP_SLA:
            begin
                r = {8'd0, a[6:0], 1'b0};
                f = {3'b000, a[7]};
            end
            OP_SRA:
            begin
                r = {8'd0, a[7], a[7:1]};
                f = {3'b000, a[0]};
            end
            OP_SRL:
            begin
                r = {8'd0, 1'b0, a[7:1]};
                f = {3'b000, a[0]};
            end
            OP_SWAP:
            begin
                r = {8'd0, a[3:0], a[7:4]};
                f = {a == '0, 3'b000};
            end
            OP_BIT:
            begin
                r  = {8'd0, a};
                f  = {(a & bit_mask) == '0, 1'b0, 1'b1, cin};
                wr = 1'b0;
            end
            OP_RES:
            begin
                r = {8'd0, a & ~bit_mask};
            end
            OP_SET:
            begin
                r = {8'd0, a | bit_mask};
            end
            OP_ADD16:
            begin
                r = sum17[WORD_W-1:0];
                f = {req.flags_in[FLAG_Z], 1'b0, sum13[12], sum17[WORD_W]};
            end
            OP_ADDSP:
            begin
                r = req.operand_a + offset16;
                f = {2'b00, sp_half[4], sp_low9[BYTE_W]};
            end
            OP_INC16:
            begin
                r = req.operand_a + 16'd1;
            end
            OP_DEC16:
            begin
                r = req.operand_a - 16'd1;
            end
            default:
            begin
                r  = '0;
                wr = 1'b0;
            end
        endcase

        // cb-prefixed rotates and shifts take z from the result
        if ((op_t'(req.operation) == OP_RLC) || (op_t'(req.operation) == OP_RRC) ||
            (op_t'(req.operation) == OP_RL)  || (op_t'(req.operation) == OP_RR)  ||
            (op_t'(req.operation) == OP_SLA) || (op_t'(req.operation) == OP_SRA) ||
            (op_t'(req.operation) == OP_SRL))
        begin
            f[FLAG_Z] = (r[BYTE_W-1:0] == '0);
        end

        rsp.result       = r;
        rsp.flags_out    = f;
        rsp.write_result = wr;
    end

endmodule

FILE: sv/cpu_alu_with_flags.sv
// cpu alu with flags: top level with input register, datapath and result register
// depends on cpu_alu_pkg, cpu_alu_if and cpu_alu_core
//
// usage:
//   req carries one operation item: operation code, operand_a, operand_b,
//   the incoming z/n/h/c flags and a bit index. rsp returns one item per
//   request: result, new flags and write_result.
//   an item is taken at a clock edge with valid and ready both high.
//   the item is captured in the input register, the datapath (one 17-bit
//   adder level plus selection) feeds the result register, where
//   rsp.valid rises, and the result is taken from there with rsp.ready.
//   throughput is one item per cycle while rsp.ready is high; req.ready
//   stays high while the result register can drain or is empty.
//   when rsp.ready is low the result is held, the input register keeps its
//   item behind it, and req.ready drops once both are full.
//   reset (rst_n low, asynchronous) empties both registers; no item is lost
//   or repeated across a stall.
module cpu_alu_with_flags
    import cpu_alu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cpu_alu_req_if.sink   req,
    cpu_alu_rsp_if.source rsp
);

    logic     in_valid_reg;
    alu_req_t in_data_reg;
    logic     out_valid_reg;
    alu_rsp_t out_data_reg;
    alu_rsp_t core_rsp;
    logic     out_advance;
    logic     in_accept;

    assign out_advance = !out_valid_reg || rsp.ready;
    assign req.ready   = !in_valid_reg || out_advance;
    assign in_accept   = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg.operation <= req.operation;
            in_data_reg.operand_a <= req.operand_a;
            in_data_reg.operand_b <= req.operand_b;
            in_data_reg.flags_in  <= req.flags_in;
            in_data_reg.bit_index <= req.bit_index;
        end
        if (out_advance && in_valid_reg)
        begin
            out_data_reg <= core_rsp;
        end
    end

    cpu_alu_core u_core (
        .req (in_data_reg),
        .rsp (core_rsp)
    );

    assign rsp.valid        = out_valid_reg;
    assign rsp.result       = out_data_reg.result;
    assign rsp.flags_out    = out_data_reg.flags_out;
    assign rsp.write_result = out_data_reg.write_result;

    // an accepted item always lands in the input register
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_valid_reg)
        else $error("accepted item not captured in input register");

    // a held item moves into the result register when it may advance
    a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_advance) |=> out_valid_reg)
        else $error("input register item not moved to result register");

    // a result only leaves after the receiver took it
    a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(rsp.ready))
        else $error("result dropped without being taken");

    // compare and bit test never request write-back
    a_no_write_cp: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_advance &&
         ((op_t'(in_data_reg.operation) == OP_CP) ||
          (op_t'(in_data_reg.operation) == OP_BIT)))
        |=> !out_data_reg.write_result)
        else $error("write_result set for compare or bit test");

endmodule
